@@ sv/vrla_pkg.sv @@
// Shared types, constants and codes for the vector rate-limited approach block.
// Used by every module of the block; depends on nothing else.
package vrla_pkg;

	// Point store geometry.
	localparam int NUM_FEET   = 4;
	localparam int NUM_POINTS = NUM_FEET + 2;
	localparam int PT_IDX_W   = $clog2(NUM_POINTS);
	localparam int AXES       = 3;
	localparam int AX_W       = $clog2(AXES);

	// Data widths.
	localparam int COORD_W = 32;
	localparam int SPEED_W = 32;
	localparam int MS_W    = 16;
	localparam int ERR_W   = 32;
	localparam int PROD_W  = SPEED_W + MS_W;
	localparam int SUM_W   = ERR_W + 2;
	// The step is below 2^48 / 1000, which needs 39 bits.
	localparam int STEP_W  = 39;
	localparam int AXP_W   = ERR_W + 32;
	localparam int DVD_W   = SUM_W + 32;
	localparam int REM_W   = SUM_W;
	localparam int QUO_W   = PROD_W;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	// Divider: two quotient bits per iteration.
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_IT_STEP  = DIV_CNT_W'(PROD_W / 2);
	localparam logic [DIV_CNT_W-1:0] DIV_IT_SHARE = DIV_CNT_W'(ERR_W / 2);

	localparam logic [REM_W-1:0] MS_PER_S = REM_W'(1000);

	localparam logic [PT_IDX_W-1:0] PT_BODY_POS  = PT_IDX_W'(0);
	localparam logic [PT_IDX_W-1:0] PT_BODY_ANG  = PT_IDX_W'(1);
	localparam logic [PT_IDX_W-1:0] PT_FOOT_BASE = PT_IDX_W'(2);
	localparam logic [AX_W-1:0]     AX_LAST      = AX_W'(AXES - 1);

	// Register reset values.
	localparam logic [DATA_W-1:0] RST_BODY_SPEED_MAX = 32'd6553600;
	localparam logic [DATA_W-1:0] RST_BODY_TURN_MAX  = 32'd65536;
	localparam logic [DATA_W-1:0] RST_FOOT_SPEED_MAX = 32'd26214400;

	typedef enum logic [1:0] {
		REG_ENABLED        = 2'd0,
		REG_BODY_SPEED_MAX = 2'd1,
		REG_BODY_TURN_MAX  = 2'd2,
		REG_FOOT_SPEED_MAX = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		GRP_BODY_POS = 2'd0,
		GRP_BODY_ANG = 2'd1,
		GRP_FOOT     = 2'd2,
		GRP_INVALID  = 2'd3
	} group_t;

	typedef enum logic {
		CMD_MOVE  = 1'b0,
		CMD_FORCE = 1'b1
	} command_t;

	typedef struct packed {
		logic              enabled;
		logic [DATA_W-1:0] body_speed_max;
		logic [DATA_W-1:0] body_turn_max;
		logic [DATA_W-1:0] foot_speed_max;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STEP_START,
		ST_STEP_WAIT,
		ST_CHECK,
		ST_AX_MUL,
		ST_AX_START,
		ST_AX_WAIT,
		ST_AX_APPLY,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic            latch;
		logic            prep;
		logic            step_start;
		logic            step_load;
		logic            force_write;
		logic            ax_mul;
		logic            ax_start;
		logic            ax_apply;
		logic            load_rsp;
		logic [AX_W-1:0] axis;
	} dp_cmd_t;

	typedef struct packed {
		logic reject;
		logic force_load;
		logic step_ge_sum;
		logic div_done;
	} dp_sts_t;

endpackage

@@ sv/vrla_regs.sv @@
// Configuration register file with its APB-style access port.
// Depends on vrla_pkg for the register map and the configuration struct.
module vrla_regs import vrla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled        <= 1'b0;
			cfg_q.body_speed_max <= RST_BODY_SPEED_MAX;
			cfg_q.body_turn_max  <= RST_BODY_TURN_MAX;
			cfg_q.foot_speed_max <= RST_FOOT_SPEED_MAX;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLED: begin
					cfg_q.enabled <= pwdata[0];
				end
				REG_BODY_SPEED_MAX: begin
					cfg_q.body_speed_max <= pwdata;
				end
				REG_BODY_TURN_MAX: begin
					cfg_q.body_turn_max <= pwdata;
				end
				REG_FOOT_SPEED_MAX: begin
					cfg_q.foot_speed_max <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLED:        prdata = {{(DATA_W-1){1'b0}}, cfg_q.enabled};
			REG_BODY_SPEED_MAX: prdata = cfg_q.body_speed_max;
			REG_BODY_TURN_MAX:  prdata = cfg_q.body_turn_max;
			REG_FOOT_SPEED_MAX: prdata = cfg_q.foot_speed_max;
			default:            prdata = '0;
		endcase
	end

endmodule

@@ sv/vrla_div.sv @@
// Iterative radix-4 restoring divider, two quotient bits per clock cycle.
// Depends on vrla_pkg for its widths.
module vrla_div import vrla_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_CNT_W-1:0] iters,
	input  logic [REM_W-1:0]     rem_init,
	input  logic [QUO_W-1:0]     dvd_init,
	input  logic [REM_W-1:0]     divisor,
	output logic                 done,
	output logic [QUO_W-1:0]     quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic [QUO_W-1:0]     dvd_q;
	logic [QUO_W-1:0]     quo_q;
	logic [REM_W-1:0]     d1_q;
	logic [REM_W:0]       d2_q;
	logic [REM_W+1:0]     d3_q;

	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] rest;
	logic [1:0]       digit;

	// The partial remainder always stays below the divisor, so the trial value
	// lies below four times the divisor and one of four digits fits.
	always_comb begin
		trial = {rem_q, dvd_q[QUO_W-1 -: 2]};
		if (trial >= d3_q) begin
			digit = 2'd3;
			rest  = trial - d3_q;
		end else if (trial >= {1'b0, d2_q}) begin
			digit = 2'd2;
			rest  = trial - {1'b0, d2_q};
		end else if (trial >= {2'b00, d1_q}) begin
			digit = 2'd1;
			rest  = trial - {2'b00, d1_q};
		end else begin
			digit = 2'd0;
			rest  = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dvd_init;
			quo_q <= '0;
			d1_q  <= divisor;
			d2_q  <= {divisor, 1'b0};
			d3_q  <= {2'b00, divisor} + {1'b0, divisor, 1'b0};
		end else if (busy_q) begin
			rem_q <= rest[REM_W-1:0];
			dvd_q <= {dvd_q[QUO_W-3:0], 2'b00};
			quo_q <= {quo_q[QUO_W-3:0], digit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while still busy");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < d1_q)
		else $error("partial remainder not below divisor");

endmodule

@@ sv/vrla_dpath.sv @@
// Datapath: point store, item registers, speed multiplier, error and share
// arithmetic around the shared divider. Depends on vrla_pkg and vrla_div.
module vrla_dpath import vrla_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      command,
	input  logic [1:0]                group,
	input  logic [1:0]                foot_index,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic [SPEED_W-1:0]        speed_request,
	input  logic [MS_W-1:0]           elapsed_ms,
	input  dp_cmd_t                   cmd,
	output dp_sts_t                   sts,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic signed [COORD_W-1:0] point_z,
	output logic                      reached,
	output logic                      rejected
);

	// Item registers.
	command_t                  command_q;
	logic [PT_IDX_W-1:0]       pidx_q;
	logic                      reject_q;
	logic [SPEED_W-1:0]        maxv_q;
	logic signed [COORD_W-1:0] tgt_q [AXES];
	logic [SPEED_W-1:0]        speed_q;
	logic [MS_W-1:0]           ms_q;

	// Working registers.
	logic [ERR_W-1:0]  err_q [AXES];
	logic              dir_q [AXES];
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  sum_q;
	logic [STEP_W-1:0] step_q;
	logic [AXP_W-1:0]  axprod_q;
	logic              reached_q;

	logic signed [COORD_W-1:0] pts_q [NUM_POINTS][AXES];

	logic signed [COORD_W-1:0] rsp_pt_q [AXES];
	logic                      rsp_reached_q;
	logic                      rsp_rejected_q;

	group_t                    grp;
	logic [PT_IDX_W-1:0]       pidx_n;
	logic [SPEED_W-1:0]        maxv_n;
	logic                      reject_n;
	logic signed [COORD_W-1:0] cur [AXES];
	logic signed [COORD_W:0]   diff [AXES];
	logic [ERR_W-1:0]          err_n [AXES];
	logic                      dir_n [AXES];
	logic [SPEED_W-1:0]        speed_eff;
	logic [ERR_W-1:0]          err_sel;
	logic [SUM_W-1:0]          hi_part;
	logic [DVD_W-1:0]          dividend;
	logic [ERR_W-1:0]          share;
	logic                      snap;
	logic signed [COORD_W-1:0] new_coord;

	logic                 div_start;
	logic [DIV_CNT_W-1:0] div_iters;
	logic [REM_W-1:0]     div_rem;
	logic [QUO_W-1:0]     div_dvd;
	logic [REM_W-1:0]     div_dsr;
	logic                 div_done;
	logic [QUO_W-1:0]     quot;

	// Decode of the incoming request.
	always_comb begin
		grp      = group_t'(group);
		reject_n = !cfg.enabled || (grp == GRP_INVALID) ||
			((grp == GRP_FOOT) && (32'(foot_index) >= NUM_FEET));
		case (grp)
			GRP_BODY_POS: begin
				pidx_n = PT_BODY_POS;
				maxv_n = cfg.body_speed_max;
			end
			GRP_BODY_ANG: begin
				pidx_n = PT_BODY_ANG;
				maxv_n = cfg.body_turn_max;
			end
			GRP_FOOT: begin
				pidx_n = PT_FOOT_BASE + PT_IDX_W'(foot_index);
				maxv_n = cfg.foot_speed_max;
			end
			default: begin
				pidx_n = PT_BODY_POS;
				maxv_n = '0;
			end
		endcase
		if (reject_n) begin
			pidx_n = PT_BODY_POS;
		end
	end

	// Per-axis error magnitude and direction of the current point.
	always_comb begin
		for (int j = 0; j < AXES; j++) begin
			cur[j]   = pts_q[pidx_q][j];
			diff[j]  = {cur[j][COORD_W-1], cur[j]} - {tgt_q[j][COORD_W-1], tgt_q[j]};
			err_n[j] = diff[j][COORD_W] ? ERR_W'(-diff[j]) : ERR_W'(diff[j]);
			dir_n[j] = ~diff[j][COORD_W];
		end
	end

	assign speed_eff = ((speed_q == '0) || (speed_q > maxv_q)) ? maxv_q : speed_q;
	assign err_sel   = err_q[cmd.axis];

	// The step is below the error sum here, so it has at most two bits above
	// the low word; their partial products are plain shifted adds.
	assign hi_part  = (step_q[ERR_W]   ? SUM_W'(err_sel)         : '0) +
		(step_q[ERR_W+1] ? SUM_W'({err_sel, 1'b0}) : '0);
	assign dividend = {2'b00, axprod_q} + {hi_part, {ERR_W{1'b0}}};

	assign share     = quot[ERR_W-1:0];
	assign snap      = err_sel <= share;
	assign new_coord = snap ? tgt_q[cmd.axis] :
		(dir_q[cmd.axis] ? cur[cmd.axis] - share : cur[cmd.axis] + share);

	// One divider serves the division by 1000 and the three axis shares.
	assign div_start = cmd.step_start || cmd.ax_start;
	assign div_iters = cmd.ax_start ? DIV_IT_SHARE : DIV_IT_STEP;
	assign div_rem   = cmd.ax_start ? dividend[DVD_W-1:ERR_W] : '0;
	assign div_dvd   = cmd.ax_start ? {dividend[ERR_W-1:0], {(QUO_W-ERR_W){1'b0}}} : prod_q;
	assign div_dsr   = cmd.ax_start ? sum_q : MS_PER_S;

	vrla_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.iters    (div_iters),
		.rem_init (div_rem),
		.dvd_init (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			command_q <= command_t'(command);
			pidx_q    <= pidx_n;
			reject_q  <= reject_n;
			maxv_q    <= maxv_n;
			tgt_q[0]  <= target_x;
			tgt_q[1]  <= target_y;
			tgt_q[2]  <= target_z;
			speed_q   <= speed_request;
			ms_q      <= elapsed_ms;
		end
		if (cmd.prep) begin
			prod_q <= PROD_W'(speed_eff) * PROD_W'(ms_q);
			for (int j = 0; j < AXES; j++) begin
				err_q[j] <= err_n[j];
				dir_q[j] <= dir_n[j];
			end
		end
		if (cmd.step_start) begin
			sum_q <= SUM_W'(err_q[0]) + SUM_W'(err_q[1]) + SUM_W'(err_q[2]);
		end
		if (cmd.step_load) begin
			step_q <= quot[STEP_W-1:0];
		end
		if (cmd.ax_mul) begin
			axprod_q <= AXP_W'(err_sel) * AXP_W'(step_q[ERR_W-1:0]);
		end
		if (cmd.load_rsp) begin
			for (int j = 0; j < AXES; j++) begin
				rsp_pt_q[j] <= reject_q ? '0 : cur[j];
			end
			rsp_reached_q  <= !reject_q && reached_q;
			rsp_rejected_q <= reject_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q <= 1'b0;
			for (int p = 0; p < NUM_POINTS; p++) begin
				for (int j = 0; j < AXES; j++) begin
					pts_q[p][j] <= '0;
				end
			end
		end else begin
			if (cmd.latch) begin
				reached_q <= 1'b1;
			end
			if (cmd.force_write) begin
				for (int j = 0; j < AXES; j++) begin
					pts_q[pidx_q][j] <= tgt_q[j];
				end
			end else if (cmd.ax_apply) begin
				pts_q[pidx_q][cmd.axis] <= new_coord;
				if (!snap) begin
					reached_q <= 1'b0;
				end
			end
		end
	end

	assign sts.reject      = reject_q;
	assign sts.force_load  = command_q == CMD_FORCE;
	assign sts.step_ge_sum = step_q >= STEP_W'(sum_q);
	assign sts.div_done    = div_done;

	assign point_x  = rsp_pt_q[0];
	assign point_y  = rsp_pt_q[1];
	assign point_z  = rsp_pt_q[2];
	assign reached  = rsp_reached_q;
	assign rejected = rsp_rejected_q;

	a_share_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ax_apply |-> share <= err_sel)
		else $error("axis share exceeds axis error");

endmodule

@@ sv/vrla_ctrl.sv @@
// Controller state machine: sequences one request through the datapath.
// Depends on vrla_pkg for the state type and the command and status structs.
module vrla_ctrl import vrla_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t     state_q;
	ctrl_state_t     state_n;
	logic [AX_W-1:0] ax_q;
	logic [AX_W-1:0] ax_n;
	logic            rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ax_q    <= ax_n;
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n   = state_q;
		ax_n      = ax_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.axis  = ax_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_n   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.prep = 1'b1;
				if (sts.reject) begin
					state_n = ST_DONE;
				end else if (sts.force_load) begin
					cmd.force_write = 1'b1;
					state_n         = ST_DONE;
				end else begin
					state_n = ST_STEP_START;
				end
			end
			ST_STEP_START: begin
				cmd.step_start = 1'b1;
				state_n        = ST_STEP_WAIT;
			end
			ST_STEP_WAIT: begin
				if (sts.div_done) begin
					cmd.step_load = 1'b1;
					state_n       = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ax_n = '0;
				if (sts.step_ge_sum) begin
					cmd.force_write = 1'b1;
					state_n         = ST_DONE;
				end else begin
					state_n = ST_AX_MUL;
				end
			end
			ST_AX_MUL: begin
				cmd.ax_mul = 1'b1;
				state_n    = ST_AX_START;
			end
			ST_AX_START: begin
				cmd.ax_start = 1'b1;
				state_n      = ST_AX_WAIT;
			end
			ST_AX_WAIT: begin
				if (sts.div_done) begin
					state_n = ST_AX_APPLY;
				end
			end
			ST_AX_APPLY: begin
				cmd.ax_apply = 1'b1;
				if (ax_q == AX_LAST) begin
					state_n = ST_DONE;
				end else begin
					ax_n    = ax_q + AX_W'(1);
					state_n = ST_AX_MUL;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_rsp = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten before it was taken");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		ax_q <= AX_LAST)
		else $error("axis counter out of range");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_STEP_WAIT || state_q == ST_AX_WAIT))
		else $error("divider finished while nobody waited for it");

endmodule

@@ sv/vector_rate_limited_approach_core.sv @@
// Vector rate-limited approach core. It keeps six 3-D points in signed Q16.16 (body position,
// body angle and four foot points) and moves one of them per request toward a target at no more
// than the clamped speed times the elapsed time, sharing the step length over the axes in
// proportion to each axis's absolute error; a force request loads the target directly, and a
// request is rejected with an all-zero point when the block is disabled or the group is invalid.
// Requests are handled one at a time. A move that needs the proportional share first divides
// the product of speed and milliseconds by 1000 to get the step length, then for each of the
// three axes runs a multiply, a set-up and a 66-by-34-bit share division, followed by an update;
// all four divisions go through one radix-4 divider that retires two quotient bits a cycle. A
// move whose step covers the whole error snaps to the target after the step division, and force
// and rejected requests bypass the divider. The result sits in an output register, so the next
// request is accepted as soon as the result is registered, even if the previous result has not
// yet been taken. The user must write configuration through the APB-style port only while no
// request is in flight; the block itself does not enforce it.
// Depends on vrla_pkg, vrla_regs, vrla_ctrl and vrla_dpath.
module vector_rate_limited_approach_core import vrla_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	// Request channel.
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic                      command,
	input  logic [1:0]                group,
	input  logic [1:0]                foot_index,
	input  logic signed [COORD_W-1:0] target_x,
	input  logic signed [COORD_W-1:0] target_y,
	input  logic signed [COORD_W-1:0] target_z,
	input  logic [SPEED_W-1:0]        speed_request,
	input  logic [MS_W-1:0]           elapsed_ms,
	// Result channel.
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic signed [COORD_W-1:0] point_z,
	output logic                      reached,
	output logic                      rejected
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// Register file: enable flag and the three per-group speed limits.
	vrla_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: accepts a request, steps the datapath through the step-length
	// division and the per-axis shares as the request needs them, then hands the result to the output
	// register once that register is free.
	vrla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: point store, arithmetic, the shared divider and the result register.
	vrla_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.command       (command),
		.group         (group),
		.foot_index    (foot_index),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_z      (target_z),
		.speed_request (speed_request),
		.elapsed_ms    (elapsed_ms),
		.cmd           (cmd),
		.sts           (sts),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.reached       (reached),
		.rejected      (rejected)
	);

endmodule
